// ===== hdl/pipt_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Shared constants, the command code of a queued item and the queue head type.
// ----------------------------------------------------------------------------
package pipt_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 24;
  localparam int unsigned VCOUNT_W         = 9;
  localparam int unsigned VINDEX_W         = 8;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned OUT_TDATA_W      = 8;

  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_SKIP  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } q_head_t;

  // Input tdata: vertex_index, coord_x, coord_y, ends_contour, padded to bytes.
  function automatic int unsigned in_tdata_w(input int unsigned coord_bits);
    return ((2 * coord_bits + VINDEX_W + 1 + 7) / 8) * 8;
  endfunction

endpackage

// ===== hdl/pipt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data is registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module pipt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pipt_front.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon front end
// Accepts input beats, classifies them as vertex write, query or dropped write,
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pipt_front #(
  parameter int unsigned MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pipt_pkg::COORD_BITS_DEF,
  localparam int unsigned AW          = $clog2(MAX_VERTICES),
  localparam int unsigned TDATA_W     = pipt_pkg::in_tdata_w(COORD_BITS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [TDATA_W-1:0]            s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  input  logic                          pop_i,
  output pipt_pkg::q_head_t             head_o,
  output logic [AW-1:0]                 head_addr_o,
  output logic signed [COORD_BITS-1:0]  head_x_o,
  output logic signed [COORD_BITS-1:0]  head_y_o,
  output logic                          head_mark_o
);
  import pipt_pkg::*;

  localparam int unsigned PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_e                   cmd_q  [QUEUE_DEPTH];
  logic [AW-1:0]          addr_q [QUEUE_DEPTH];
  logic [COORD_BITS-1:0]  x_q    [QUEUE_DEPTH];
  logic [COORD_BITS-1:0]  y_q    [QUEUE_DEPTH];
  logic                   mark_q [QUEUE_DEPTH];

  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [VINDEX_W-1:0]   in_index;
  logic [COORD_BITS-1:0] in_x, in_y;
  logic                  in_mark;
  cmd_e                  in_cmd;
  logic                  push;

  assign in_index = s_axis_tdata_i[VINDEX_W-1:0];
  assign in_x     = s_axis_tdata_i[VINDEX_W +: COORD_BITS];
  assign in_y     = s_axis_tdata_i[VINDEX_W+COORD_BITS +: COORD_BITS];
  assign in_mark  = s_axis_tdata_i[VINDEX_W+2*COORD_BITS];

  // Writes to slots beyond the table are dropped but still kept in order.
  always_comb begin
    if (s_axis_tuser_i == FUNC_QUERY) begin
      in_cmd = CMD_QUERY;
    end else if (32'(in_index) < MAX_VERTICES) begin
      in_cmd = CMD_WRITE;
    end else begin
      in_cmd = CMD_SKIP;
    end
  end

  assign s_axis_tready_o = (count_q < CNT_W'(QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q]  <= in_cmd;
      addr_q[wr_ptr_q] <= AW'(in_index);
      x_q[wr_ptr_q]    <= in_x;
      y_q[wr_ptr_q]    <= in_y;
      mark_q[wr_ptr_q] <= in_mark;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = cmd_q[rd_ptr_q];
  assign head_addr_o  = addr_q[rd_ptr_q];
  assign head_x_o     = x_q[rd_ptr_q];
  assign head_y_o     = y_q[rd_ptr_q];
  assign head_mark_o  = mark_q[rd_ptr_q];

endmodule

// ===== hdl/pipt_back.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon back end
// Executes queued items: vertex writes go to the table RAM, queries walk the
// table one edge per cycle through a three-stage crossing-test pipeline.
// ----------------------------------------------------------------------------
module pipt_back #(
  parameter int unsigned MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pipt_pkg::COORD_BITS_DEF,
  localparam int unsigned AW          = $clog2(MAX_VERTICES)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [pipt_pkg::VCOUNT_W-1:0]    vertex_count_i,
  input  pipt_pkg::q_head_t                head_i,
  input  logic [AW-1:0]                    head_addr_i,
  input  logic signed [COORD_BITS-1:0]     head_x_i,
  input  logic signed [COORD_BITS-1:0]     head_y_i,
  input  logic                             head_mark_i,
  output logic                             pop_o,
  output logic                             busy_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [pipt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o  // [0] inside_res
);
  import pipt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned P  = 2 * D;
  localparam int unsigned RW = 2 * COORD_BITS + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_CLOSE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [C-1:0] px_q, px_d, py_q, py_d;
  logic signed [C-1:0] fx_q, fx_d, fy_q, fy_d;
  logic signed [C-1:0] prx_q, prx_d, pry_q, pry_d;
  logic [CW-1:0]       n_q, n_d, rd_idx_q, rd_idx_d, n_eff;
  logic                dv_q, dv_d, last_tag_q, last_tag_d, first_q, first_d;
  logic                par_q, par_d, inside_q, inside_d;
  logic                out_valid_q, out_valid_d, out_data_q, out_data_d;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic signed [C-1:0] vx, vy;
  logic                vmark, end_v, close_now, issue;

  // Edge emitted this cycle: i is the current vertex, j the previous one.
  logic                emit, emit_close;
  logic signed [C-1:0] exi, eyi, exj, eyj;
  logic                spans;

  // Difference stage
  logic                e1_v_q, e1_sp_q, e1_cl_q, e1_pos_q;
  logic signed [D-1:0] e1_a_q, e1_dy_q, e1_dx_q, e1_b_q;
  logic signed [D-1:0] dy_w;
  // Product stage
  logic                m_v_q, m_sp_q, m_cl_q, m_pos_q;
  logic signed [P-1:0] m_p1_q, m_p2_q, prod1, prod2;
  logic                left, par_next;

  pipt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {head_mark_i, head_y_i, head_x_i};
  assign vx        = ram_rdata[C-1:0];
  assign vy        = ram_rdata[2*C-1:C];
  assign vmark     = ram_rdata[2*C];
  assign end_v     = vmark || last_tag_q;
  // The last vertex of a contour of two or more vertices also has an edge back to
  // the first one, so the read stream pauses and the RAM output is held for that edge.
  assign close_now = dv_q && end_v && !first_q;

  assign n_eff = (32'(vertex_count_i) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                      : CW'(vertex_count_i);

  assign left     = m_pos_q ? (m_p1_q < m_p2_q) : (m_p2_q < m_p1_q);
  assign par_next = par_q ^ (m_v_q && m_sp_q && left);

  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    prx_d       = prx_q;
    pry_d       = pry_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    dv_d        = dv_q;
    last_tag_d  = last_tag_q;
    first_d     = first_q;
    par_d       = par_q;
    inside_d    = inside_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = rd_idx_q[AW-1:0];
    issue       = 1'b0;
    emit        = 1'b0;
    emit_close  = 1'b0;
    exi         = vx;
    eyi         = vy;
    exj         = prx_q;
    eyj         = pry_q;

    // Parity of the contour being tested; closing edges fold it into the answer.
    if (m_v_q) begin
      if (m_cl_q) begin
        inside_d = inside_q || par_next;
        par_d    = 1'b0;
      end else begin
        par_d = par_next;
      end
    end

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        ram_addr = head_addr_i;
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.cmd)
            CMD_WRITE: begin
              ram_we = 1'b1;
            end
            CMD_QUERY: begin
              px_d     = head_x_i;
              py_d     = head_y_i;
              n_d      = n_eff;
              rd_idx_d = '0;
              dv_d     = 1'b0;
              first_d  = 1'b1;
              par_d    = 1'b0;
              inside_d = 1'b0;
              state_d  = (n_eff == '0) ? S_DONE : S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        issue = (rd_idx_q < n_q) && !close_now;
        if (dv_q) begin
          emit  = !first_q;
          prx_d = vx;
          pry_d = vy;
          if (first_q) begin
            fx_d = vx;
            fy_d = vy;
          end
          first_d = first_q && end_v;
          if (close_now) begin
            state_d = S_CLOSE;
          end else if (last_tag_q) begin
            state_d = S_DRAIN;
          end
        end
        if (issue) begin
          ram_re     = 1'b1;
          rd_idx_d   = rd_idx_q + CW'(1);
          last_tag_d = (rd_idx_q == n_q - CW'(1));
        end
        dv_d = issue;
      end
      S_CLOSE: begin
        emit       = 1'b1;
        emit_close = 1'b1;
        exi        = fx_q;
        eyi        = fy_q;
        exj        = vx;
        eyj        = vy;
        first_d    = 1'b1;
        issue      = (rd_idx_q < n_q);
        if (issue) begin
          ram_re     = 1'b1;
          rd_idx_d   = rd_idx_q + CW'(1);
          last_tag_d = (rd_idx_q == n_q - CW'(1));
        end
        dv_d    = issue;
        state_d = last_tag_q ? S_DRAIN : S_WALK;
      end
      S_DRAIN: begin
        if (!e1_v_q && !m_v_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = inside_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Half-open span test on y; the x test follows from the sign of dy.
  assign spans = ((eyi <= py_q) && (py_q < eyj)) || ((eyj <= py_q) && (py_q < eyi));
  assign dy_w  = D'(eyj) - D'(eyi);
  assign prod1 = e1_a_q * e1_dy_q;
  assign prod2 = e1_dx_q * e1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dv_q        <= 1'b0;
      e1_v_q      <= 1'b0;
      m_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dv_q        <= dv_d;
      e1_v_q      <= emit;
      m_v_q       <= e1_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    prx_q      <= prx_d;
    pry_q      <= pry_d;
    n_q        <= n_d;
    rd_idx_q   <= rd_idx_d;
    last_tag_q <= last_tag_d;
    first_q    <= first_d;
    par_q      <= par_d;
    inside_q   <= inside_d;
    out_data_q <= out_data_d;

    e1_sp_q  <= spans;
    e1_cl_q  <= emit_close;
    e1_pos_q <= (dy_w > 0);
    e1_a_q   <= D'(px_q) - D'(exi);
    e1_dy_q  <= dy_w;
    e1_dx_q  <= D'(exj) - D'(exi);
    e1_b_q   <= D'(py_q) - D'(eyi);

    m_sp_q  <= e1_sp_q;
    m_cl_q  <= e1_cl_q;
    m_pos_q <= e1_pos_q;
    m_p1_q  <= prod1;
    m_p2_q  <= prod2;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-1){1'b0}}, out_data_q};

endmodule

// ===== hdl/point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test unit
// A query walks the N vertices in use plus a closing edge for each of the K
// contours of two or more vertices, one edge per cycle over the single table
// RAM port.
// Throughput: one item at a time in the back end; a two-beat queue and the
// output register let input and output stall independently.
// Reset: control state and vertex_count clear; the vertex table has no reset.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit #(
  parameter int unsigned MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pipt_pkg::COORD_BITS_DEF,
  localparam int unsigned TDATA_W     = pipt_pkg::in_tdata_w(COORD_BITS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pipt_pkg::VCOUNT_W-1:0]    cfg_wdata_i,      // vertex_count
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // vertex_index, coord_x, coord_y, ends_contour, zero padding
  input  logic [TDATA_W-1:0]               s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,   // func
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [pipt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o    // inside_res, zero padding
);
  import pipt_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  logic [VCOUNT_W-1:0]          vertex_count_q;
  q_head_t                      head;
  logic [AW-1:0]                head_addr;
  logic signed [COORD_BITS-1:0] head_x, head_y;
  logic                         head_mark;
  logic                         pop, busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  pipt_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .pop_i           (pop),
    .head_o          (head),
    .head_addr_o     (head_addr),
    .head_x_o        (head_x),
    .head_y_o        (head_y),
    .head_mark_o     (head_mark)
  );

  pipt_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vertex_count_i  (vertex_count_q),
    .head_i          (head),
    .head_addr_i     (head_addr),
    .head_x_i        (head_x),
    .head_y_i        (head_y),
    .head_mark_i     (head_mark),
    .pop_o           (pop),
    .busy_o          (busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`ifndef SYNTH
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> head.valid)
    else $error("input stalled with an empty queue");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.cmd == CMD_QUERY) |=> busy)
    else $error("query popped but back end did not start");
`endif

endmodule

// ===== verif/point_in_polygon_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon result checker
// Watches the input and result streams and the vertex_count register. It keeps
// its own copy of the vertex table, predicts the inside flag of every accepted
// query by crossing-number parity, and compares it with the result beats.
// ----------------------------------------------------------------------------
module point_in_polygon_checker
  import pipt_pkg::*;
#(
  parameter int unsigned COORD_W = COORD_BITS_DEF,
  parameter int unsigned DEPTH   = MAX_VERTICES_DEF,
  parameter int unsigned IN_W    = in_tdata_w(COORD_BITS_DEF)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [VCOUNT_W-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [IN_W-1:0]        in_data_i,
  input  logic                   in_user_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_TDATA_W-1:0] out_data_i,
  output int                     outstanding_o,
  output int                     mismatch_count_o,
  output int                     inside_count_o
);

  logic signed [COORD_W-1:0] vert_x [DEPTH];
  logic signed [COORD_W-1:0] vert_y [DEPTH];
  logic                      vert_end [DEPTH];
  logic [VCOUNT_W-1:0]       vertices_in_use;
  logic                      inside_expected_q [$];

  // Parity of the crossings of one contour, walked from the closing edge on.
  function automatic logic contour_crossings_odd(input int first, input int last,
                                                 input longint px, input longint py);
    longint xi, yi, xj, yj, dy;
    logic   odd, left;
    int     j;
    odd = 1'b0;
    j   = last;
    for (int i = first; i <= last; i++) begin
      xi = vert_x[i];
      yi = vert_y[i];
      xj = vert_x[j];
      yj = vert_y[j];
      if ((yi <= py && py < yj) || (yj <= py && py < yi)) begin
        dy = yj - yi;
        // Products stay below 2^51, so the cross-multiplied compare is exact.
        if (dy > 0) begin
          left = (px - xi) * dy < (xj - xi) * (py - yi);
        end else begin
          left = (xj - xi) * (py - yi) < (px - xi) * dy;
        end
        if (left) begin
          odd = ~odd;
        end
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic logic predict_inside(input longint px, input longint py);
    int   in_use;
    int   first;
    logic hit;
    in_use = (vertices_in_use > DEPTH) ? DEPTH : int'(vertices_in_use);
    first  = 0;
    hit    = 1'b0;
    for (int i = 0; i < in_use; i++) begin
      if (vert_end[i] || i == in_use - 1) begin
        if (contour_crossings_odd(first, i, px, py)) begin
          hit = 1'b1;
        end
        first = i + 1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [COORD_W-1:0] beat_x, beat_y;
    logic [VINDEX_W-1:0]       beat_idx;
    logic                      expected;
    if (!rst_ni) begin
      vertices_in_use  <= '0;
      outstanding_o    <= 0;
      mismatch_count_o <= 0;
      inside_count_o   <= 0;
      inside_expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (inside_expected_q.size() == 0) begin
          $display("%0t: result beat with no query waiting: expected none, actual %0b",
                   $time, out_data_i[0]);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          expected = inside_expected_q.pop_front();
          if (out_data_i[0] !== expected) begin
            $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                     $time, expected, out_data_i[0]);
            mismatch_count_o <= mismatch_count_o + 1;
          end
          if (out_data_i[0] === 1'b1) begin
            inside_count_o <= inside_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        beat_idx = in_data_i[VINDEX_W-1:0];
        beat_x   = in_data_i[VINDEX_W +: COORD_W];
        beat_y   = in_data_i[VINDEX_W + COORD_W +: COORD_W];
        if (in_user_i == FUNC_QUERY) begin
          inside_expected_q.push_back(predict_inside(beat_x, beat_y));
        end else if (beat_idx < DEPTH) begin
          vert_x[beat_idx]   = beat_x;
          vert_y[beat_idx]   = beat_y;
          vert_end[beat_idx] = in_data_i[VINDEX_W + 2 * COORD_W];
        end
      end
      if (cfg_we_i) begin
        vertices_in_use <= cfg_wdata_i;
      end
      outstanding_o <= inside_expected_q.size();
    end
  end

endmodule

// ===== verif/point_in_polygon_test_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon test unit testbench
// Loads vertex tables of one or more contours, sets vertex_count while the
// block is idle and streams point queries mixed with vertex rewrites. Both
// streams idle and stall at random; a checker predicts and compares results.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit_tb;
  import pipt_pkg::*;

  localparam int unsigned COORD_W     = COORD_BITS_DEF;
  localparam int unsigned IN_W        = in_tdata_w(COORD_BITS_DEF);
  localparam int unsigned TABLE_DEPTH = MAX_VERTICES_DEF;
  localparam logic        FUNC_WRITE  = ~FUNC_QUERY;
  localparam longint      COORD_MIN   = -(longint'(1) << (COORD_W - 1));
  localparam longint      COORD_MAX   = (longint'(1) << (COORD_W - 1)) - 1;
  localparam logic signed [COORD_W-1:0] COORD_LOWEST  = COORD_MIN[COORD_W-1:0];
  localparam logic signed [COORD_W-1:0] COORD_HIGHEST = COORD_MAX[COORD_W-1:0];
  localparam int          COUNT_TOP     = (1 << VCOUNT_W) - 1;
  localparam int          ITEMS_TARGET  = 1900;
  localparam int          SETTLE_CYCLES = 20;
  localparam longint      LIMIT_CYCLES  = 5_000_000;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [VCOUNT_W-1:0]    cfg_wdata_i     = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_W-1:0]        s_axis_tdata_i  = '0;
  logic                   s_axis_tuser_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  int     outstanding, mismatch_count, inside_count;
  int     items_sent     = 0;
  int     writes_sent    = 0;
  int     queries_sent   = 0;
  int     settings_done  = 0;
  int     stall_left     = 0;
  logic   no_idle        = 1'b0;
  longint cycle_count    = 0;
  longint box_lo, box_hi, probe_lo, probe_hi;
  logic signed [COORD_W-1:0] phase_x [TABLE_DEPTH];
  logic signed [COORD_W-1:0] phase_y [TABLE_DEPTH];

  point_in_polygon_test_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  point_in_polygon_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_i       (s_axis_tready_o),
    .in_data_i        (s_axis_tdata_i),
    .in_user_i        (s_axis_tuser_i),
    .out_valid_i      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_data_i       (m_axis_tdata_o),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatch_count),
    .inside_count_o   (inside_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return $urandom_range(12, 40);
    end
    if (roll < 40) begin
      return $urandom_range(1, 3);
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (no_idle) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 3) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= idle_len();
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // The extremes of the box come up often so that edges share exact values.
  function automatic logic signed [COORD_W-1:0] coord_between(input longint lo,
                                                              input longint hi);
    int unsigned span;
    int unsigned roll;
    span = int'(hi - lo);
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return lo[COORD_W-1:0];
    end
    if (roll == 1) begin
      return hi[COORD_W-1:0];
    end
    return COORD_W'(lo + longint'($urandom_range(0, span)));
  endfunction

  function automatic void choose_box();
    longint half, mid;
    if ($urandom_range(0, 3) == 0) begin
      box_lo   = COORD_MIN;
      box_hi   = COORD_MAX;
      probe_lo = COORD_MIN;
      probe_hi = COORD_MAX;
    end else begin
      half     = longint'(1) << $urandom_range(2, 21);
      mid      = COORD_MIN + half
                 + longint'($urandom_range(0, int'(COORD_MAX - COORD_MIN - 2 * half)));
      box_lo   = mid - half;
      box_hi   = mid + half;
      probe_lo = (box_lo - half / 2 < COORD_MIN) ? COORD_MIN : box_lo - half / 2;
      probe_hi = (box_hi + half / 2 > COORD_MAX) ? COORD_MAX : box_hi + half / 2;
    end
  endfunction

  task automatic send_beat(input logic func, input logic [VINDEX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, input logic ends);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= {{(IN_W - VINDEX_W - 2 * COORD_W - 1){1'b0}}, ends, y, x, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic send_write(input int idx, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic ends);
    phase_x[idx] = x;
    phase_y[idx] = y;
    send_beat(FUNC_WRITE, idx[VINDEX_W-1:0], x, y, ends);
    writes_sent++;
  endtask

  // The slot index and contour-end bits are don't-care on a query.
  task automatic send_query(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    send_beat(FUNC_QUERY, VINDEX_W'($urandom_range(0, 255)), x, y,
              1'($urandom_range(0, 1)));
    queries_sent++;
  endtask

  // Let every query result come back and any trailing vertex write land.
  task automatic drain_block();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_vertex_count(input int value);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[VCOUNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_done++;
  endtask

  // Fills slots 0 .. n-1 with contours of random length, short ones included.
  task automatic load_contours(input int n);
    int slot, len;
    slot = 0;
    while (slot < n) begin
      if ($urandom_range(0, 7) == 0) begin
        len = n - slot;
      end else if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 2);
      end else begin
        len = $urandom_range(3, 9);
      end
      if (len > n - slot) begin
        len = n - slot;
      end
      for (int k = 0; k < len; k++) begin
        send_write(slot + k, coord_between(box_lo, box_hi), coord_between(box_lo, box_hi),
                   (k != len - 1) ? 1'b0 :
                   (slot + len == n) ? 1'($urandom_range(0, 1)) : 1'b1);
      end
      slot += len;
    end
  endtask

  // Points level with vertices, at vertex x values or on edge midpoints hit ties.
  task automatic probe_point(input int n);
    logic signed [COORD_W-1:0] qx, qy;
    int roll, i;
    qx   = coord_between(probe_lo, probe_hi);
    qy   = coord_between(probe_lo, probe_hi);
    roll = $urandom_range(0, 7);
    if (n > 0 && roll < 2) begin
      qy = phase_y[$urandom_range(0, n - 1)];
      if (roll == 0) begin
        qx = phase_x[$urandom_range(0, n - 1)];
      end
    end else if (n > 1 && roll == 2) begin
      i  = $urandom_range(0, n - 2);
      qx = COORD_W'((longint'(phase_x[i]) + longint'(phase_x[i + 1])) >>> 1);
      qy = COORD_W'((longint'(phase_y[i]) + longint'(phase_y[i + 1])) >>> 1);
    end
    send_query(qx, qy);
  endtask

  initial begin
    int phase_no, n, vcount, nq, roll;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // An empty table answers outside everywhere.
    set_vertex_count(0);
    send_query(0, 0);
    send_query(COORD_LOWEST, COORD_HIGHEST);

    // A 256 by 256 square, a lone vertex, a triangle at the coordinate limits and a
    // two-vertex contour whose last vertex has no end mark.
    send_write(0, 0, 0, 1'b0);
    send_write(1, 256, 0, 1'b0);
    send_write(2, 256, 256, 1'b0);
    send_write(3, 0, 256, 1'b1);
    send_write(4, 512, 512, 1'b1);
    send_write(5, COORD_LOWEST, COORD_LOWEST, 1'b0);
    send_write(6, COORD_HIGHEST, COORD_LOWEST, 1'b0);
    send_write(7, 0, COORD_HIGHEST, 1'b1);
    send_write(8, 1000, -50, 1'b0);
    send_write(9, 1000, 50, 1'b0);
    set_vertex_count(10);
    send_query(128, 128);
    send_query(300, 128);
    send_query(0, 128);
    send_query(256, 128);
    send_query(0, 0);
    send_query(128, 0);
    send_query(128, 256);
    send_query(512, 512);
    send_query(1000, 0);
    send_query(COORD_LOWEST, COORD_LOWEST);
    send_query(COORD_HIGHEST, COORD_HIGHEST);
    send_query(COORD_LOWEST, COORD_HIGHEST);

    phase_no = 0;
    while (items_sent < ITEMS_TARGET) begin
      phase_no++;
      roll = $urandom_range(0, 19);
      if (phase_no == 2 || roll == 0) begin
        n = TABLE_DEPTH;
      end else if (roll == 1) begin
        n = 0;
      end else if (roll < 6) begin
        n = $urandom_range(25, 80);
      end else begin
        n = $urandom_range(1, 24);
      end
      no_idle <= ($urandom_range(0, 3) == 0);
      choose_box();
      load_contours(n);
      // A count above the table size saturates; a smaller one cuts a contour.
      if (n == TABLE_DEPTH) begin
        vcount = (phase_no == 2) ? COUNT_TOP :
                 ($urandom_range(0, 1) != 0) ? TABLE_DEPTH :
                 $urandom_range(TABLE_DEPTH + 1, COUNT_TOP);
      end else if (n > 0 && $urandom_range(0, 4) == 0) begin
        vcount = $urandom_range(1, n);
      end else begin
        vcount = n;
      end
      set_vertex_count(vcount);
      nq = (n > 80) ? $urandom_range(6, 14) : $urandom_range(20, 60);
      repeat (nq) begin
        if ($urandom_range(0, 6) == 0) begin
          send_write($urandom_range(0, TABLE_DEPTH - 1), coord_between(box_lo, box_hi),
                     coord_between(box_lo, box_hi), 1'($urandom_range(0, 1)));
        end else begin
          probe_point(n);
        end
      end
    end

    drain_block();
    $display("Run covered %0d vertex writes and %0d point queries over %0d vertex_count settings,",
             writes_sent, queries_sent, settings_done);
    $display("from an empty table to a saturated one; %0d answers were inside a contour.",
             inside_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
